### design/cnms_pkg.sv
package cnms_pkg;

  localparam int RULE_SLOTS_DEF = 8;

  localparam int MINS_PER_HOUR = 60;
  localparam int MINS_PER_DAY  = 1440;
  localparam int MINS_PER_WEEK = 10080;
  localparam int HOURS_PER_DAY = 24;
  localparam int DAYS_PER_WEEK = 7;

  localparam int MINUTE_W  = 60;
  localparam int HOUR_W    = 24;
  localparam int WEEKDAY_W = 7;
  localparam int RULE_W    = MINUTE_W + HOUR_W + WEEKDAY_W;
  localparam int TIME_W    = 14;

  // width of the shared first-set search word and of a bit position in it
  localparam int SEARCH_W = 64;
  localparam int POS_W    = 6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register index carried in the word address bit of the config port
  localparam logic REG_ACTIVE_RULE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    STATUS_MATCH    = 2'd0,
    STATUS_NO_RULES = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_SPLITD,
    S_SPLITH,
    S_READ,
    S_CHECK,
    S_HOUR0,
    S_MIN0,
    S_HOUR1,
    S_DAY,
    S_HFIRST,
    S_MFIRST,
    S_SUM,
    S_CMP,
    S_NEXT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } ffs_res_t;

endpackage

### design/cron_next_match_search.sv
// Weekly cron next-match search. A load transaction (tuser command 0) writes
// one rule slot (minute, hour and weekday masks) and returns nothing. A
// query transaction (tuser command 1) returns one result: the nearest time
// at or after the start, over the first active_rule_count rules, with the
// minutes from the start to it; status 1 means no active rules and status 2
// means some active rule has an empty mask, with all other fields 0.
// Querying an active slot that was never loaded gives an undefined answer.
// The block handles one query at a time and is not ready while it runs. A
// query runs setup states that wrap and split the start time, then a pass
// for each active rule, then states that wrap and split the match time
// (skipped when some rule has an empty mask; a query with no active rules
// goes straight to its result); the passes use the single shared first-set
// search unit, which the sequencer applies to the weekday, hour and minute
// masks in turn, one search per cycle. Results leave through an output
// register, so a query may be accepted while the last result waits.
module cron_next_match_search #(
  parameter int RULE_SLOTS = cnms_pkg::RULE_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // slave stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] rule_slot, [62:3] minute_mask, [86:63] hour_mask,
  // [93:87] weekday_mask, [96:94] start_weekday, [101:97] start_hour,
  // [107:102] start_minute, [111:108] zero
  input  logic [111:0] in_tdata,
  // [0] command
  input  logic [0:0]   in_tuser,
  // master stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] match_weekday, [7:3] match_hour, [13:8] match_minute,
  // [27:14] minutes_ahead, [31:28] zero
  output logic [31:0]  out_tdata,
  // [1:0] status
  output logic [1:0]   out_tuser,
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int CW  = $clog2(RULE_SLOTS + 1);
  localparam int AW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int TW  = cnms_pkg::TIME_W;
  localparam int TW1 = TW + 1;

  // input fields
  logic                             in_cmd;
  logic [2:0]                       in_slot;
  logic [cnms_pkg::MINUTE_W-1:0]    in_mm;
  logic [cnms_pkg::HOUR_W-1:0]      in_hm;
  logic [cnms_pkg::WEEKDAY_W-1:0]   in_wm;
  logic [2:0]                       in_sw;
  logic [4:0]                       in_sh;
  logic [5:0]                       in_sm;

  assign in_cmd  = in_tuser[0];
  assign in_slot = in_tdata[2:0];
  assign in_mm   = in_tdata[62:3];
  assign in_hm   = in_tdata[86:63];
  assign in_wm   = in_tdata[93:87];
  assign in_sw   = in_tdata[96:94];
  assign in_sh   = in_tdata[101:97];
  assign in_sm   = in_tdata[107:102];

  // state and registers
  cnms_pkg::state_t  state_r, state_nxt;
  cnms_pkg::status_t status_r, status_nxt;
  logic              phase_r, phase_nxt;       // 0: start time, 1: match time
  logic [TW-1:0]     val_r, val_nxt;
  logic [TW-1:0]     s_r, s_nxt;
  logic [10:0]       sod_r, sod_nxt;
  logic [2:0]        sw_r, sw_nxt;
  logic [4:0]        sh_r, sh_nxt;
  logic [5:0]        sm_r, sm_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TW-1:0]     best_r, best_nxt;
  logic              any_empty_r, any_empty_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [4:0]        h_r, h_nxt;
  logic [5:0]        m_r, m_nxt;
  logic [TW-1:0]     ahead_r, ahead_nxt;
  logic [3:0]        cfg_count_r, cfg_count_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [31:0]       out_tdata_r, out_tdata_nxt;
  logic [1:0]        out_tuser_r, out_tuser_nxt;

  // rule table
  logic                             ram_we;
  logic [cnms_pkg::RULE_W-1:0]      ram_rdata;
  logic [cnms_pkg::MINUTE_W-1:0]    rd_mm;
  logic [cnms_pkg::HOUR_W-1:0]      rd_hm;
  logic [cnms_pkg::WEEKDAY_W-1:0]   rd_wm;
  logic                             rule_empty;

  // shared search unit
  logic [cnms_pkg::SEARCH_W-1:0]    ffs_word;
  logic [cnms_pkg::POS_W-1:0]       ffs_from;
  cnms_pkg::ffs_res_t               ffs_res;

  // arithmetic
  logic [CW-1:0]  eff_cnt;
  logic [TW-1:0]  start_val;
  logic [TW-1:0]  wrap_val;
  logic [2:0]     day_q;
  logic [TW-1:0]  day_rem;
  logic [4:0]     hr_q;
  logic [TW-1:0]  hr_rem;
  logic [TW-1:0]  ahead_val;
  logic [TW1-1:0] match_sum;
  logic           in_fire;
  logic           emit_fire;
  logic           last_rule;
  logic           cfg_wr;

  cnms_ram #(
    .WIDTH (cnms_pkg::RULE_W),
    .DEPTH (RULE_SLOTS)
  ) u_rule_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_slot)),
    .wdata ({in_wm, in_hm, in_mm}),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_mm      = ram_rdata[59:0];
  assign rd_hm      = ram_rdata[83:60];
  assign rd_wm      = ram_rdata[90:84];
  assign rule_empty = (rd_mm == '0) || (rd_hm == '0) || (rd_wm == '0);

  cnms_ffs u_ffs (
    .word (ffs_word),
    .from (ffs_from),
    .res  (ffs_res)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == cnms_pkg::REG_ACTIVE_RULE_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == cnms_pkg::REG_ACTIVE_RULE_COUNT) ?
                      {28'd0, cfg_count_r} : 32'd0;
  assign cfg_count_nxt = cfg_wr ? cfg_pwdata[3:0] : cfg_count_r;

  always_comb begin
    if (32'(cfg_count_r) > 32'(RULE_SLOTS)) begin
      eff_cnt = CW'(RULE_SLOTS);
    end else begin
      eff_cnt = CW'(cfg_count_r);
    end
  end

  // time arithmetic
  always_comb begin
    start_val = TW'(in_sw) * TW'(cnms_pkg::MINS_PER_DAY) +
                TW'(in_sh) * TW'(cnms_pkg::MINS_PER_HOUR) + TW'(in_sm);
    if (val_r >= TW'(cnms_pkg::MINS_PER_WEEK)) begin
      wrap_val = val_r - TW'(cnms_pkg::MINS_PER_WEEK);
    end else begin
      wrap_val = val_r;
    end
    day_q = '0;
    for (int j = 1; j < cnms_pkg::DAYS_PER_WEEK; j++) begin
      if (val_r >= TW'(j * cnms_pkg::MINS_PER_DAY)) begin
        day_q = 3'(j);
      end
    end
    day_rem = val_r - TW'(day_q) * TW'(cnms_pkg::MINS_PER_DAY);
    hr_q = '0;
    for (int j = 1; j < cnms_pkg::HOURS_PER_DAY; j++) begin
      if (val_r >= TW'(j * cnms_pkg::MINS_PER_HOUR)) begin
        hr_q = 5'(j);
      end
    end
    hr_rem    = val_r - TW'(hr_q) * TW'(cnms_pkg::MINS_PER_HOUR);
    ahead_val = TW'(k_r) * TW'(cnms_pkg::MINS_PER_DAY) +
                TW'(h_r) * TW'(cnms_pkg::MINS_PER_HOUR) + TW'(m_r) - TW'(sod_r);
    // start plus lead can pass one week, so keep the carry
    match_sum = TW1'(s_r) + TW1'(best_r);
  end

  assign in_fire   = in_tvalid && in_tready;
  assign emit_fire = (state_r == cnms_pkg::S_EMIT) && (!out_tvalid_r || out_tready);
  assign last_rule = (CW'(idx_r + 1'b1) == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cnms_pkg::S_IDLE: begin
        if (in_fire && in_cmd == cnms_pkg::CMD_QUERY) begin
          state_nxt = (eff_cnt == '0) ? cnms_pkg::S_EMIT : cnms_pkg::S_WRAP;
        end
      end
      cnms_pkg::S_WRAP:   state_nxt = cnms_pkg::S_SPLITD;
      cnms_pkg::S_SPLITD: state_nxt = cnms_pkg::S_SPLITH;
      cnms_pkg::S_SPLITH: state_nxt = phase_r ? cnms_pkg::S_EMIT : cnms_pkg::S_READ;
      cnms_pkg::S_READ:   state_nxt = cnms_pkg::S_CHECK;
      cnms_pkg::S_CHECK: begin
        if (rule_empty) begin
          state_nxt = cnms_pkg::S_NEXT;
        end else if (rd_wm[sw_r]) begin
          state_nxt = cnms_pkg::S_HOUR0;
        end else begin
          state_nxt = cnms_pkg::S_DAY;
        end
      end
      cnms_pkg::S_HOUR0: begin
        if (!ffs_res.found) begin
          state_nxt = cnms_pkg::S_DAY;
        end else if (ffs_res.pos == 6'(sh_r)) begin
          state_nxt = cnms_pkg::S_MIN0;
        end else begin
          state_nxt = cnms_pkg::S_MFIRST;
        end
      end
      cnms_pkg::S_MIN0: begin
        state_nxt = ffs_res.found ? cnms_pkg::S_SUM : cnms_pkg::S_HOUR1;
      end
      cnms_pkg::S_HOUR1: begin
        state_nxt = ffs_res.found ? cnms_pkg::S_MFIRST : cnms_pkg::S_DAY;
      end
      cnms_pkg::S_DAY:    state_nxt = cnms_pkg::S_HFIRST;
      cnms_pkg::S_HFIRST: state_nxt = cnms_pkg::S_MFIRST;
      cnms_pkg::S_MFIRST: state_nxt = cnms_pkg::S_SUM;
      cnms_pkg::S_SUM:    state_nxt = cnms_pkg::S_CMP;
      cnms_pkg::S_CMP:    state_nxt = cnms_pkg::S_NEXT;
      cnms_pkg::S_NEXT: begin
        if (!last_rule) begin
          state_nxt = cnms_pkg::S_READ;
        end else if (any_empty_r) begin
          state_nxt = cnms_pkg::S_EMIT;
        end else begin
          state_nxt = cnms_pkg::S_WRAP;
        end
      end
      cnms_pkg::S_EMIT: begin
        if (emit_fire) begin
          state_nxt = cnms_pkg::S_IDLE;
        end
      end
      default: state_nxt = cnms_pkg::S_IDLE;
    endcase
  end

  // state outputs: handshake, table write and search operands
  always_comb begin
    in_tready = (state_r == cnms_pkg::S_IDLE);
    ram_we    = (state_r == cnms_pkg::S_IDLE) && in_tvalid &&
                (in_cmd == cnms_pkg::CMD_LOAD) && (32'(in_slot) < 32'(RULE_SLOTS));
    ffs_word  = '0;
    ffs_from  = '0;
    case (state_r)
      cnms_pkg::S_HOUR0: begin
        ffs_word = cnms_pkg::SEARCH_W'(rd_hm);
        ffs_from = 6'(sh_r);
      end
      cnms_pkg::S_MIN0: begin
        ffs_word = cnms_pkg::SEARCH_W'(rd_mm);
        ffs_from = 6'(sm_r);
      end
      cnms_pkg::S_HOUR1: begin
        ffs_word = cnms_pkg::SEARCH_W'(rd_hm);
        ffs_from = 6'(sh_r) + 6'd1;
      end
      cnms_pkg::S_DAY: begin
        // doubled weekday mask: the search finds the next set day after the start day, wrapping around the week
        ffs_word = cnms_pkg::SEARCH_W'({rd_wm, rd_wm});
        ffs_from = 6'(sw_r) + 6'd1;
      end
      cnms_pkg::S_HFIRST: ffs_word = cnms_pkg::SEARCH_W'(rd_hm);
      cnms_pkg::S_MFIRST: ffs_word = cnms_pkg::SEARCH_W'(rd_mm);
      default: begin
        ffs_word = '0;
        ffs_from = '0;
      end
    endcase
  end

  // datapath
  always_comb begin
    status_nxt    = status_r;
    phase_nxt     = phase_r;
    val_nxt       = val_r;
    s_nxt         = s_r;
    sod_nxt       = sod_r;
    sw_nxt        = sw_r;
    sh_nxt        = sh_r;
    sm_nxt        = sm_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    any_empty_nxt = any_empty_r;
    k_nxt         = k_r;
    h_nxt         = h_r;
    m_nxt         = m_r;
    ahead_nxt     = ahead_r;
    case (state_r)
      cnms_pkg::S_IDLE: begin
        if (in_fire && in_cmd == cnms_pkg::CMD_QUERY) begin
          cnt_nxt    = eff_cnt;
          val_nxt    = start_val;
          phase_nxt  = 1'b0;
          status_nxt = cnms_pkg::STATUS_NO_RULES;
        end
      end
      cnms_pkg::S_WRAP: begin
        val_nxt = wrap_val;
        if (!phase_r) begin
          s_nxt = wrap_val;
        end
      end
      cnms_pkg::S_SPLITD: begin
        sw_nxt  = day_q;
        val_nxt = day_rem;
      end
      cnms_pkg::S_SPLITH: begin
        sh_nxt = hr_q;
        sm_nxt = 6'(hr_rem);
        if (!phase_r) begin
          sod_nxt       = 11'(val_r);
          idx_nxt       = '0;
          best_nxt      = TW'(cnms_pkg::MINS_PER_WEEK);
          any_empty_nxt = 1'b0;
        end else begin
          status_nxt = cnms_pkg::STATUS_MATCH;
        end
      end
      cnms_pkg::S_CHECK: begin
        if (rule_empty) begin
          any_empty_nxt = 1'b1;
        end
      end
      cnms_pkg::S_HOUR0: begin
        k_nxt = '0;
        h_nxt = 5'(ffs_res.pos);
      end
      cnms_pkg::S_MIN0: begin
        k_nxt = '0;
        h_nxt = sh_r;
        m_nxt = ffs_res.pos;
      end
      cnms_pkg::S_HOUR1: begin
        k_nxt = '0;
        h_nxt = 5'(ffs_res.pos);
      end
      cnms_pkg::S_DAY:    k_nxt = 3'(ffs_res.pos - 6'(sw_r));
      cnms_pkg::S_HFIRST: h_nxt = 5'(ffs_res.pos);
      cnms_pkg::S_MFIRST: m_nxt = ffs_res.pos;
      cnms_pkg::S_SUM:    ahead_nxt = ahead_val;
      cnms_pkg::S_CMP: begin
        if (ahead_r < best_r) begin
          best_nxt = ahead_r;
        end
      end
      cnms_pkg::S_NEXT: begin
        idx_nxt = CW'(idx_r + 1'b1);
        if (last_rule) begin
          if (any_empty_r) begin
            status_nxt = cnms_pkg::STATUS_EMPTY;
          end else begin
            if (match_sum >= TW1'(cnms_pkg::MINS_PER_WEEK)) begin
              val_nxt = TW'(match_sum - TW1'(cnms_pkg::MINS_PER_WEEK));
            end else begin
              val_nxt = TW'(match_sum);
            end
            phase_nxt = 1'b1;
          end
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  // result register
  always_comb begin
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    if (emit_fire) begin
      out_tvalid_nxt = 1'b1;
      out_tuser_nxt  = status_r;
      if (status_r == cnms_pkg::STATUS_MATCH) begin
        out_tdata_nxt = {4'd0, best_r, sm_r, sh_r, sw_r};
      end else begin
        out_tdata_nxt = '0;
      end
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cnms_pkg::S_IDLE;
      phase_r      <= 1'b0;
      cfg_count_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      cfg_count_r  <= cfg_count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    val_r       <= val_nxt;
    s_r         <= s_nxt;
    sod_r       <= sod_nxt;
    sw_r        <= sw_nxt;
    sh_r        <= sh_nxt;
    sm_r        <= sm_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    best_r      <= best_nxt;
    any_empty_r <= any_empty_nxt;
    k_r         <= k_nxt;
    h_r         <= h_nxt;
    m_r         <= m_nxt;
    ahead_r     <= ahead_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### design/cnms_ram.sv
module cnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/cnms_ffs.sv
// Find the lowest set bit of word at or above position from.
module cnms_ffs (
  input  logic [cnms_pkg::SEARCH_W-1:0] word,
  input  logic [cnms_pkg::POS_W-1:0]    from,
  output cnms_pkg::ffs_res_t            res
);

  logic [cnms_pkg::SEARCH_W-1:0] masked;
  logic [cnms_pkg::SEARCH_W-1:0] lowest;

  always_comb begin
    masked    = word & ({cnms_pkg::SEARCH_W{1'b1}} << from);
    // isolate the lowest set bit, then encode its one-hot position
    lowest    = masked & (~masked + cnms_pkg::SEARCH_W'(1));
    res.found = |masked;
    res.pos   = '0;
    for (int j = 0; j < cnms_pkg::SEARCH_W; j++) begin
      if (lowest[j]) begin
        res.pos = res.pos | cnms_pkg::POS_W'(j);
      end
    end
  end

endmodule
